[rtl/assert_macros.svh]
// Assertion macros used by the checker file fsp_checker.
// No dependencies; each checker using these provides a clock and reset signal.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, disabled during reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fsp_pkg.sv]
// Types, codes and constants of the format specifier parser.
// No dependencies; used by fsp_step, format_spec_parser and fsp_checker.
package fsp_pkg;

   localparam int NUMBER_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

   // characters
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LOW_H  = 8'h68;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_CAP_L  = 8'h4C;
   localparam logic [7:0] CH_LOW_D  = 8'h64;
   localparam logic [7:0] CH_LOW_I  = 8'h69;
   localparam logic [7:0] CH_LOW_O  = 8'h6F;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_CAP_X  = 8'h58;
   localparam logic [7:0] CH_LOW_C  = 8'h63;
   localparam logic [7:0] CH_LOW_S  = 8'h73;
   localparam logic [7:0] CH_LOW_P  = 8'h70;
   localparam logic [7:0] CH_LOW_F  = 8'h66;

   // flag bit positions
   localparam int FLAG_MINUS = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_ZERO  = 3;
   localparam int FLAG_HASH  = 4;

   // length modifier codes
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_H    = 3'd1;
   localparam logic [2:0] LEN_HH   = 3'd2;
   localparam logic [2:0] LEN_L    = 3'd3;
   localparam logic [2:0] LEN_LL   = 3'd4;
   localparam logic [2:0] LEN_BIGL = 3'd5;

   // conversion codes
   localparam logic [3:0] CONV_D   = 4'd0;
   localparam logic [3:0] CONV_I   = 4'd1;
   localparam logic [3:0] CONV_O   = 4'd2;
   localparam logic [3:0] CONV_U   = 4'd3;
   localparam logic [3:0] CONV_X   = 4'd4;
   localparam logic [3:0] CONV_BX  = 4'd5;
   localparam logic [3:0] CONV_C   = 4'd6;
   localparam logic [3:0] CONV_S   = 4'd7;
   localparam logic [3:0] CONV_P   = 4'd8;
   localparam logic [3:0] CONV_F   = 4'd9;
   localparam logic [3:0] CONV_PCT = 4'd10;

   localparam logic [4:0] RADIX_OCT = 5'd8;
   localparam logic [4:0] RADIX_DEC = 5'd10;
   localparam logic [4:0] RADIX_HEX = 5'd16;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef enum logic [2:0] {
      PH_FLAGS,
      PH_WIDTH,
      PH_PREC,
      PH_LEN_H,
      PH_LEN_L,
      PH_LEN_BIGL,
      PH_LEN_DONE
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [4:0]             flags_seen;
      logic [NUMBER_BITS-1:0] width_accum;
      logic                   dot_seen;
      logic [NUMBER_BITS-1:0] precision_accum;
      logic [2:0]             length_code;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:           PH_FLAGS,
      flags_seen:      5'd0,
      width_accum:     '0,
      dot_seen:        1'b0,
      precision_accum: '0,
      length_code:     LEN_NONE
   };

   typedef struct packed {
      logic [1:0]            prefix_length;
      logic [4:0]            radix;
      logic [3:0]            conversion;
      logic [2:0]            length_mod;
      logic [FIELD_BITS-1:0] precision_value;
      logic                  precision_given;
      logic [FIELD_BITS-1:0] field_width;
      logic [4:0]            flag_bits;
      logic                  status;
   } result_type;

endpackage

[rtl/fsp_step.sv]
// One parse step: next parser state and optional result for one character.
// Depends on fsp_pkg.
module fsp_step
   import fsp_pkg::*;
(
   input  logic [7:0]      character,
   input  parse_state_type state,
   output parse_state_type next_state,
   output logic            result_valid,
   output result_type      result
);

   localparam int AccBits = NUMBER_BITS + 4;

   logic       is_digit;
   logic [3:0] digit_val;
   logic       conv_ok;
   logic [3:0] conv_val;
   logic       is_flag;
   phase_type  tail_phase;
   phase_type  next_phase;
   logic [NUMBER_BITS-1:0] width_next;
   logic [NUMBER_BITS-1:0] prec_next;

   function automatic logic [NUMBER_BITS-1:0] accumulate(
      input logic [NUMBER_BITS-1:0] acc,
      input logic [3:0]             digit
   );
      logic [AccBits-1:0] v;
      v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{NUMBER_BITS{1'b0}}, digit};
      return (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[NUMBER_BITS-1:0];
   endfunction

   function automatic result_type make_done(
      input parse_state_type st,
      input logic [3:0]      conv,
      input logic [2:0]      len
   );
      result_type r;
      r.status          = STATUS_OK;
      r.flag_bits       = st.flags_seen;
      r.field_width     = FIELD_BITS'(st.width_accum);
      r.precision_given = st.dot_seen;
      r.precision_value = FIELD_BITS'(st.precision_accum);
      r.length_mod      = len;
      r.conversion      = conv;
      case (conv)
         CONV_X, CONV_BX, CONV_P: begin
            r.radix = RADIX_HEX; r.prefix_length = 2'd2;
         end
         CONV_O: begin
            r.radix = RADIX_OCT; r.prefix_length = 2'd1;
         end
         default: begin
            r.radix = RADIX_DEC; r.prefix_length = 2'd0;
         end
      endcase
      return r;
   endfunction

   function automatic result_type make_error();
      result_type r;
      r       = '0;
      r.status = STATUS_BAD;
      r.radix  = RADIX_DEC;
      return r;
   endfunction

   // character decode
   always_comb begin
      is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
      digit_val = 4'(character - CH_ZERO);
      is_flag   = (character == CH_ZERO) || (character == CH_HASH) ||
                  (character == CH_SPACE) || (character == CH_MINUS) ||
                  (character == CH_PLUS);
      conv_ok   = 1'b1;
      unique case (character)
         CH_LOW_D: conv_val = CONV_D;
         CH_LOW_I: conv_val = CONV_I;
         CH_LOW_O: conv_val = CONV_O;
         CH_LOW_U: conv_val = CONV_U;
         CH_LOW_X: conv_val = CONV_X;
         CH_CAP_X: conv_val = CONV_BX;
         CH_LOW_C: conv_val = CONV_C;
         CH_LOW_S: conv_val = CONV_S;
         CH_LOW_P: conv_val = CONV_P;
         CH_LOW_F: conv_val = CONV_F;
         CH_PCT:   conv_val = CONV_PCT;
         default: begin
            conv_val = CONV_D;
            conv_ok  = 1'b0;
         end
      endcase
      width_next = accumulate((state.phase == PH_FLAGS) ? '0 : state.width_accum, digit_val);
      prec_next  = accumulate(state.precision_accum, digit_val);
   end

   // phase after the shared tail of the flags, width and precision phases
   always_comb begin
      if (character == CH_DOT && state.phase != PH_PREC) tail_phase = PH_PREC;
      else if (character == CH_LOW_H)                    tail_phase = PH_LEN_H;
      else if (character == CH_LOW_L)                    tail_phase = PH_LEN_L;
      else if (character == CH_CAP_L)                    tail_phase = PH_LEN_BIGL;
      else                                               tail_phase = PH_FLAGS;
   end

   // next state of the phase machine
   always_comb begin
      unique case (state.phase)
         PH_FLAGS: begin
            if (is_flag)       next_phase = PH_FLAGS;
            else if (is_digit) next_phase = PH_WIDTH;
            else               next_phase = tail_phase;
         end
         PH_WIDTH, PH_PREC: begin
            if (is_digit) next_phase = state.phase;
            else          next_phase = tail_phase;
         end
         PH_LEN_H:
            next_phase = (character == CH_LOW_H) ? PH_LEN_DONE : PH_FLAGS;
         PH_LEN_L:
            next_phase = (character == CH_LOW_L) ? PH_LEN_DONE : PH_FLAGS;
         default: next_phase = PH_FLAGS;
      endcase
   end

   // data state and result
   always_comb begin
      next_state.phase           = next_phase;
      next_state.flags_seen      = state.flags_seen;
      next_state.width_accum     = state.width_accum;
      next_state.dot_seen        = state.dot_seen;
      next_state.precision_accum = state.precision_accum;
      next_state.length_code     = state.length_code;
      result_valid = 1'b0;
      result       = make_error();

      unique case (state.phase)
         PH_FLAGS, PH_WIDTH, PH_PREC: begin
            if (state.phase == PH_FLAGS && is_flag) begin
               case (character)
                  CH_ZERO:
                     if (!state.flags_seen[FLAG_MINUS])
                        next_state.flags_seen[FLAG_ZERO] = 1'b1;
                  CH_HASH: next_state.flags_seen[FLAG_HASH] = 1'b1;
                  CH_SPACE:
                     if (!state.flags_seen[FLAG_PLUS])
                        next_state.flags_seen[FLAG_SPACE] = 1'b1;
                  CH_MINUS: begin
                     next_state.flags_seen[FLAG_ZERO]  = 1'b0;
                     next_state.flags_seen[FLAG_MINUS] = 1'b1;
                  end
                  default: begin
                     next_state.flags_seen[FLAG_SPACE] = 1'b0;
                     next_state.flags_seen[FLAG_PLUS]  = 1'b1;
                  end
               endcase
            end else if (is_digit && state.phase != PH_PREC) begin
               next_state.width_accum = width_next;
            end else if (is_digit) begin
               next_state.precision_accum = prec_next;
            end else if (tail_phase == PH_PREC) begin
               next_state.dot_seen        = 1'b1;
               next_state.precision_accum = '0;
            end else if (tail_phase == PH_FLAGS) begin
               // conversion or stray byte ends the specifier
               result_valid = 1'b1;
               result = conv_ok ? make_done(state, conv_val, LEN_NONE) : make_error();
            end
         end
         PH_LEN_H, PH_LEN_L: begin
            if (character == CH_LOW_H && state.phase == PH_LEN_H) begin
               next_state.length_code = LEN_HH;
            end else if (character == CH_LOW_L && state.phase == PH_LEN_L) begin
               next_state.length_code = LEN_LL;
            end else begin
               result_valid = 1'b1;
               result = conv_ok ? make_done(state, conv_val,
                                  (state.phase == PH_LEN_H) ? LEN_H : LEN_L)
                                : make_error();
            end
         end
         PH_LEN_BIGL: begin
            result_valid = 1'b1;
            result = (character == CH_LOW_F) ? make_done(state, CONV_F, LEN_BIGL)
                                             : make_error();
         end
         PH_LEN_DONE: begin
            result_valid = 1'b1;
            result = conv_ok ? make_done(state, conv_val, state.length_code) : make_error();
         end
         default: begin
            result_valid = 1'b1;
            result       = make_error();
         end
      endcase

      if (result_valid) begin
         next_state.flags_seen      = STATE_CLEAR.flags_seen;
         next_state.width_accum     = STATE_CLEAR.width_accum;
         next_state.dot_seen        = STATE_CLEAR.dot_seen;
         next_state.precision_accum = STATE_CLEAR.precision_accum;
         next_state.length_code     = STATE_CLEAR.length_code;
      end
   end

endmodule

[rtl/format_spec_parser.sv]
// Top level of the format specifier parser: input register, parser state,
// result register. Depends on fsp_pkg and fsp_step.
//
//   channel | dir | payload
//   req_    | in  | tdata[7:0] character
//   rsp_    | out | tuser[0] status, tdata[51:0] specifier fields
//
// One character per cycle while req_tready is high. A character is held in
// the input register, is parsed by fsp_step and its result, if any, lands
// in the result register.
// Synchronous reset returns the parser to the flags phase with empty fields.
// A stalled result holds both stages; req_tready drops only while both are full.
module format_spec_parser
   import fsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // flag_bits[4:0], field_width[20:5],
                                    // precision_given[21], precision_value[37:22],
                                    // length_mod[40:38], conversion[44:41],
                                    // radix[49:45], prefix_length[51:50], zero pad
   output logic [0:0]  rsp_tuser    // [0] status
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      char_ff, char_in;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   result_type      result_ff, result_in;

   logic            advance;
   logic            step_valid;
   result_type      step_result;
   parse_state_type step_state;

   fsp_step u_step (
      .character    (char_ff),
      .state        (state_ff),
      .next_state   (step_state),
      .result_valid (step_valid),
      .result       (step_result)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      char_in      = char_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = in_valid_ff && step_valid;
         result_in    = step_result;
         if (in_valid_ff) state_in = step_state;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         char_in     = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.status;
   assign rsp_tdata  = {4'd0, result_ff[$bits(result_type)-1:1]};

endmodule

[rtl/fsp_checker.sv]
// Port-level checks for format_spec_parser, bound to the top level.
// Depends on fsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsp_checker
   import fsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic [4:0]  radix;
   logic [1:0]  prefix;
   logic [3:0]  conv;
   logic [2:0]  len;
   logic [56:0] rsp_word;
   logic        hex_conv;
   logic        oct_conv;
   logic        radix_ok;

   assign radix    = rsp_tdata[49:45];
   assign prefix   = rsp_tdata[51:50];
   assign conv     = rsp_tdata[44:41];
   assign len      = rsp_tdata[40:38];
   assign rsp_word = {rsp_tuser, rsp_tdata};
   assign hex_conv = (conv == CONV_X) || (conv == CONV_BX) || (conv == CONV_P);
   assign oct_conv = (conv == CONV_O);
   assign radix_ok = ((radix == RADIX_HEX) == hex_conv) && ((radix == RADIX_OCT) == oct_conv) &&
                     ((prefix == 2'd2) == hex_conv) && ((prefix == 2'd1) == oct_conv);

   // stalled transaction holds
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word), "stalled result changed")

   // malformed result carries only radix ten
   `ASSERT_IMPLY(a_err_fields, rsp_tvalid && rsp_tuser[0], rsp_tdata == {4'd0, 2'd0, RADIX_DEC, 45'd0}, "malformed result fields not clear")

   // radix and prefix agree with the conversion
   `ASSERT_IMPLY(a_radix, rsp_tvalid && !rsp_tuser[0], radix_ok, "radix or prefix mismatch")

   // capital L only with f
   `ASSERT_IMPLY(a_bigl, rsp_tvalid && !rsp_tuser[0] && len == LEN_BIGL, conv == CONV_F, "L modifier without f")

   `ASSERT_NEXT_RST(a_reset, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
